// File: src/ipp_pkg.sv
// Shared types, constants and helper functions of the IP address text parser.
package ipp_pkg;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_V6_LEAD = 3'd1,
        PH_V6_BODY = 3'd2,
        PH_V6_QUAD = 3'd3,
        PH_V4_BODY = 3'd4
    } t_phase;

    typedef struct packed {
        t_phase           phase;
        logic             fault;
        logic [7:0][15:0] groups;
        logic [3:0]       gf;
        logic             gap;
        logic [3:0]       gap_pos;
        logic [15:0]      hex;
        logic             tok;
        logic [7:0]       dacc;
        logic             dinv;
        logic             cclosed;
        logic [3:0][7:0]  octets;
        logic [2:0]       oct;
    } t_scan_state;

    typedef struct packed {
        logic        valid_res;
        logic [63:0] upper;
        logic [63:0] lower;
    } t_result;

    localparam logic [0:0] RegFamily = 1'b0;
    localparam logic [7:0] ChColon   = 8'h3A;
    localparam logic [7:0] ChDot     = 8'h2E;
    localparam logic [4:0] HexNone   = 5'd16;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = HexNone;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = 5'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = 5'(c - 8'h37);
        end
        return r;
    endfunction

    function automatic logic [11:0] times_ten(input logic [7:0] a);
        return {1'b0, a, 3'b000} + {3'b000, a, 1'b0};
    endfunction

endpackage

// File: src/ip_address_text_parser.sv
// Top level of the streaming IPv4/IPv6 address text parser.
//
//  channel  direction  handshake          payload
//  input    in         i_valid / o_stall  i_character, i_end_of_text
//  result   out        o_valid / i_stall  o_valid_res, o_address_upper, o_address_lower
//  config   in         APB write/read     i_paddr, i_pwdata, o_prdata
//
// One character per cycle while o_stall is low: each transaction is held in the input
// register, then updates the parse state; a terminator loads the result register.
// A terminator passes through the input register and then the result register.
// Reset is synchronous; it clears the parse state and selects IPv4.
// o_stall rises only while a terminator waits behind a result that is stalled.
module ip_address_text_parser
    import ipp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_character,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_valid_res,
    output logic [63:0] o_address_upper,
    output logic [63:0] o_address_lower,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic        r_family;
    logic        r_in_valid;
    logic [7:0]  r_char;
    logic        r_eot;
    logic        r_out_valid;
    t_result     r_res;
    logic        blocked;
    logic        go;
    t_scan_state scan_st;
    t_result     fin_res;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2:2] == RegFamily) ? {31'd0, r_family} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_family <= 1'b0;
        end else if (i_psel && i_penable && i_pwrite && i_paddr[2:2] == RegFamily) begin
            r_family <= i_pwdata[0];
        end
    end

    assign blocked = r_in_valid && r_eot && r_out_valid && i_stall;
    assign go      = r_in_valid && !blocked;
    assign o_stall = blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!blocked) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !blocked) begin
            r_char <= i_character;
            r_eot  <= i_end_of_text;
        end
    end

    ipp_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (go),
        .i_family      (r_family),
        .i_character   (r_char),
        .i_end_of_text (r_eot),
        .o_state       (scan_st)
    );

    ipp_finish u_finish (
        .i_state  (scan_st),
        .o_result (fin_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && r_eot) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && r_eot) begin
            r_res <= fin_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_valid_res     = r_res.valid_res;
    assign o_address_upper = r_res.upper;
    assign o_address_lower = r_res.lower;

    a_stall_only_on_eot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_eot && r_out_valid))
        else $error("stall raised without a waiting terminator");

    a_clear_after_eot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && r_eot) |=> (scan_st.phase == PH_START && !scan_st.fault && scan_st.gf == 4'd0))
        else $error("parse state not cleared after terminator");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> (o_address_upper == 64'd0 && o_address_lower == 64'd0))
        else $error("invalid result carries a nonzero address");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && r_eot) |=> o_valid)
        else $error("terminator did not produce a result");

endmodule

// File: src/ipp_scan.sv
// Per-character parse state and its update for one address string.
module ipp_scan
    import ipp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic        i_family,
    input  logic [7:0]  i_character,
    input  logic        i_end_of_text,
    output t_scan_state o_state
);

    t_scan_state r_st;
    t_scan_state n_st;
    logic        run_v6;
    logic        run_quad;
    logic [4:0]  h;
    logic [11:0] v;
    logic [7:0]  base;

    always_comb begin
        n_st     = r_st;
        run_v6   = 1'b0;
        run_quad = 1'b0;
        h        = hex_value(i_character);
        v        = '0;
        base     = r_st.tok ? r_st.dacc : 8'd0;

        if (!r_st.fault) begin
            unique case (r_st.phase)
                PH_START: begin
                    if (!i_family) begin
                        n_st.phase = PH_V4_BODY;
                        run_quad   = 1'b1;
                    end else if (i_character == ChColon) begin
                        n_st.phase = PH_V6_LEAD;
                    end else begin
                        n_st.phase = PH_V6_BODY;
                        run_v6     = 1'b1;
                    end
                end
                PH_V6_LEAD: begin
                    if (i_character != ChColon) begin
                        n_st.fault = 1'b1;
                    end else begin
                        n_st.phase = PH_V6_BODY;
                        run_v6     = 1'b1;
                    end
                end
                PH_V6_BODY: begin
                    run_v6 = 1'b1;
                end
                PH_V6_QUAD, PH_V4_BODY: begin
                    run_quad = 1'b1;
                end
                default: begin
                    n_st.fault = 1'b1;
                end
            endcase
        end

        if (run_quad) begin
            if (h < 5'd10) begin
                if (!r_st.tok && r_st.oct >= 3'd4) begin
                    n_st.fault = 1'b1;
                end else begin
                    if (!r_st.tok) begin
                        n_st.oct = r_st.oct + 3'd1;
                        n_st.tok = 1'b1;
                    end
                    v = times_ten(base) + {7'b0, h};
                    if (v > 12'd255) begin
                        n_st.fault = 1'b1;
                    end else begin
                        n_st.dacc = v[7:0];
                        n_st.octets[2'(n_st.oct - 3'd1)] = v[7:0];
                    end
                end
            end else if (i_character == ChDot && r_st.tok) begin
                if (r_st.oct >= 3'd4) begin
                    n_st.fault = 1'b1;
                end else begin
                    n_st.tok  = 1'b0;
                    n_st.dacc = 8'd0;
                end
            end else begin
                n_st.fault = 1'b1;
            end
        end

        if (run_v6) begin
            n_st.cclosed = 1'b0;
            if (h != HexNone) begin
                if (r_st.hex[15:12] != 4'd0) begin
                    n_st.fault = 1'b1;
                end else begin
                    n_st.hex = {r_st.hex[11:0], h[3:0]};
                    n_st.tok = 1'b1;
                    if (h > 5'd9) begin
                        n_st.dinv = 1'b1;
                    end else if (!r_st.dinv) begin
                        v = times_ten(r_st.dacc) + {7'b0, h};
                        if (v > 12'd255) begin
                            n_st.dinv = 1'b1;
                        end else begin
                            n_st.dacc = v[7:0];
                        end
                    end
                end
            end else if (i_character == ChColon) begin
                if (!r_st.tok) begin
                    if (r_st.gap) begin
                        n_st.fault = 1'b1;
                    end else begin
                        n_st.gap     = 1'b1;
                        n_st.gap_pos = r_st.gf;
                    end
                end else if (r_st.gf >= 4'd8) begin
                    n_st.fault = 1'b1;
                end else begin
                    n_st.groups[r_st.gf[2:0]] = r_st.hex;
                    n_st.gf      = r_st.gf + 4'd1;
                    n_st.cclosed = 1'b1;
                    n_st.hex     = 16'd0;
                    n_st.tok     = 1'b0;
                    n_st.dacc    = 8'd0;
                    n_st.dinv    = 1'b0;
                end
            end else if (i_character == ChDot && r_st.tok && !r_st.dinv
                         && r_st.gf <= 4'd6) begin
                n_st.phase     = PH_V6_QUAD;
                n_st.octets[0] = r_st.dacc;
                n_st.oct       = 3'd1;
                n_st.tok       = 1'b0;
                n_st.dacc      = 8'd0;
                n_st.hex       = 16'd0;
            end else begin
                n_st.fault = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_go) begin
            if (i_end_of_text) begin
                r_st <= '0;
            end else begin
                r_st <= n_st;
            end
        end
    end

    assign o_state = r_st;

endmodule

// File: src/ipp_finish.sv
// End-of-string check, gap expansion and address packing.
module ipp_finish
    import ipp_pkg::*;
(
    input  t_scan_state i_state,
    output t_result     o_result
);

    logic [7:0][15:0] g;
    logic [7:0][15:0] e;
    logic [3:0]       n;
    logic [3:0]       p;
    logic             ok;
    logic             v4;

    always_comb begin
        g  = i_state.groups;
        n  = i_state.gf;
        p  = i_state.gap_pos;
        ok = 1'b0;
        v4 = 1'b0;
        e  = '0;
        o_result = '0;

        unique case (i_state.phase)
            PH_V4_BODY: begin
                v4 = 1'b1;
                ok = (i_state.oct >= 3'd4);
            end
            PH_V6_BODY: begin
                ok = !i_state.cclosed;
                if (i_state.tok) begin
                    if (n >= 4'd8) begin
                        ok = 1'b0;
                    end else begin
                        g[n[2:0]] = i_state.hex;
                        n = n + 4'd1;
                    end
                end
            end
            PH_V6_QUAD: begin
                ok = (i_state.oct >= 3'd4) && (n <= 4'd6);
                g[n[2:0]]         = {i_state.octets[0], i_state.octets[1]};
                g[n[2:0] + 3'd1]  = {i_state.octets[2], i_state.octets[3]};
                n = n + 4'd2;
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        if (!v4) begin
            if (i_state.gap) begin
                if (n >= 4'd8 || p > n) begin
                    ok = 1'b0;
                end
                for (int i = 0; i < 8; i++) begin
                    if (5'(i) < {1'b0, p}) begin
                        e[i] = g[i];
                    end else if (5'(i) + {1'b0, n} >= 5'd8 + {1'b0, p}) begin
                        e[i] = g[3'(i) + n[2:0]];
                    end
                end
            end else begin
                if (n != 4'd8) begin
                    ok = 1'b0;
                end
                e = g;
            end
        end

        if (i_state.fault) begin
            ok = 1'b0;
        end

        o_result.valid_res = ok;
        if (ok) begin
            if (v4) begin
                o_result.lower = {32'd0, i_state.octets[0], i_state.octets[1],
                                  i_state.octets[2], i_state.octets[3]};
            end else begin
                o_result.upper = {e[0], e[1], e[2], e[3]};
                o_result.lower = {e[4], e[5], e[6], e[7]};
            end
        end
    end

endmodule

// File: verif/tb_ip_address_text_parser.sv
// Self-checking testbench of ip_address_text_parser: directed strings, then random address text.
module tb_ip_address_text_parser;
    import ipp_pkg::*;

    localparam int NumVectors    = 9;
    localparam int NumPhases     = 8;
    localparam int ItemsPerPhase = 212;
    localparam int CycleLimit    = 600000;
    localparam logic [2:0] FamilyAddr = {RegFamily, 2'b00};

    typedef struct {
        logic    fam;
        string   text;
        logic    typed;
        t_result want;
    } t_vector;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_character;
    logic        i_end_of_text;
    logic        o_valid;
    logic        i_stall;
    logic        o_valid_res;
    logic [63:0] o_address_upper;
    logic [63:0] o_address_lower;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [2:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    ip_address_text_parser uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_character    (i_character),
        .i_end_of_text  (i_end_of_text),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_valid_res    (o_valid_res),
        .o_address_upper(o_address_upper),
        .o_address_lower(o_address_lower),
        .i_psel         (i_psel),
        .i_penable      (i_penable),
        .i_pwrite       (i_pwrite),
        .i_paddr        (i_paddr),
        .i_pwdata       (i_pwdata),
        .o_prdata       (o_prdata),
        .o_pready       (o_pready)
    );

    t_vector          vectors [NumVectors];
    t_result          pending_addrs [$];
    int               mismatch_count = 0;
    int               results_seen = 0;
    int               cycle_count = 0;
    logic             calm;
    logic             fam_reg;

    t_phase           scan_phase;
    logic             scan_fault;
    logic [7:0][15:0] groups;
    int               n_groups;
    logic             gap_open;
    int               gap_at;
    logic [15:0]      hex_acc;
    logic             in_token;
    logic [7:0]       dec_acc;
    logic             dec_bad;
    logic             colon_last;
    logic [3:0][7:0]  octets;
    int               n_octets;

    function automatic void flag_error(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch: %s", what);
        end
    endfunction

    function automatic void clear_scan();
        scan_phase = PH_START;
        scan_fault = 1'b0;
        groups     = '0;
        n_groups   = 0;
        gap_open   = 1'b0;
        gap_at     = 0;
        hex_acc    = '0;
        in_token   = 1'b0;
        dec_acc    = '0;
        dec_bad    = 1'b0;
        colon_last = 1'b0;
        octets     = '0;
        n_octets   = 0;
    endfunction

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return int'(c - "0");
        end else if (c >= "a" && c <= "f") begin
            return int'(c - "a") + 10;
        end else if (c >= "A" && c <= "F") begin
            return int'(c - "A") + 10;
        end
        return 16;
    endfunction

    function automatic void scan_quad(input logic [7:0] c);
        int v;
        if (c >= "0" && c <= "9") begin
            if (!in_token) begin
                if (n_octets >= 4) begin
                    scan_fault = 1'b1;
                    return;
                end
                n_octets++;
                dec_acc  = '0;
                in_token = 1'b1;
            end
            v = int'(dec_acc) * 10 + int'(c - "0");
            if (v > 255) begin
                scan_fault = 1'b1;
                return;
            end
            dec_acc = v[7:0];
            octets[(n_octets - 1) & 3] = v[7:0];
        end else if (c == ChDot && in_token) begin
            if (n_octets >= 4) begin
                scan_fault = 1'b1;
                return;
            end
            in_token = 1'b0;
            dec_acc  = '0;
        end else begin
            scan_fault = 1'b1;
        end
    endfunction

    function automatic void scan_hex(input logic [7:0] c);
        int h;
        int v;
        h = nibble_of(c);
        colon_last = 1'b0;
        if (h < 16) begin
            if (hex_acc[15:12] != 4'h0) begin
                scan_fault = 1'b1;
                return;
            end
            hex_acc  = {hex_acc[11:0], 4'(h)};
            in_token = 1'b1;
            if (h > 9) begin
                dec_bad = 1'b1;
            end else if (!dec_bad) begin
                v = int'(dec_acc) * 10 + h;
                if (v > 255) begin
                    dec_bad = 1'b1;
                end else begin
                    dec_acc = v[7:0];
                end
            end
            return;
        end
        if (c == ChColon) begin
            if (!in_token) begin
                if (gap_open) begin
                    scan_fault = 1'b1;
                    return;
                end
                gap_open = 1'b1;
                gap_at   = n_groups;
                return;
            end
            if (n_groups >= 8) begin
                scan_fault = 1'b1;
                return;
            end
            groups[n_groups] = hex_acc;
            n_groups++;
            colon_last = 1'b1;
            hex_acc    = '0;
            in_token   = 1'b0;
            dec_acc    = '0;
            dec_bad    = 1'b0;
            return;
        end
        if (c == ChDot && in_token && !dec_bad && n_groups <= 6) begin
            scan_phase = PH_V6_QUAD;
            octets[0]  = dec_acc;
            n_octets   = 1;
            in_token   = 1'b0;
            dec_acc    = '0;
            hex_acc    = '0;
            return;
        end
        scan_fault = 1'b1;
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        if (scan_fault) begin
            return;
        end
        if (scan_phase == PH_START) begin
            if (!fam_reg) begin
                scan_phase = PH_V4_BODY;
            end else if (c == ChColon) begin
                scan_phase = PH_V6_LEAD;
                return;
            end else begin
                scan_phase = PH_V6_BODY;
            end
        end else if (scan_phase == PH_V6_LEAD) begin
            if (c != ChColon) begin
                scan_fault = 1'b1;
                return;
            end
            scan_phase = PH_V6_BODY;
        end
        case (scan_phase)
            PH_V6_BODY: begin
                scan_hex(c);
            end
            PH_V6_QUAD, PH_V4_BODY: begin
                scan_quad(c);
            end
            default: begin
                scan_fault = 1'b1;
            end
        endcase
    endfunction

    function automatic t_result address_of_text();
        t_result          r;
        logic [7:0][15:0] g;
        int               n;
        int               p;
        int               m;
        int               i;
        r = '0;
        if (scan_fault) begin
            return r;
        end
        case (scan_phase)
            PH_V4_BODY: begin
                if (n_octets < 4) begin
                    return r;
                end
                r.valid_res = 1'b1;
                r.lower     = {32'h0, octets[0], octets[1], octets[2], octets[3]};
                return r;
            end
            PH_V6_BODY: begin
                if (colon_last) begin
                    return r;
                end
                if (in_token) begin
                    if (n_groups >= 8) begin
                        return r;
                    end
                    groups[n_groups] = hex_acc;
                    n_groups++;
                end
            end
            PH_V6_QUAD: begin
                if (n_octets < 4 || n_groups > 6) begin
                    return r;
                end
                groups[n_groups]     = {octets[0], octets[1]};
                groups[n_groups + 1] = {octets[2], octets[3]};
                n_groups += 2;
            end
            default: begin
                return r;
            end
        endcase
        if (gap_open) begin
            n = n_groups;
            p = gap_at;
            if (n >= 8 || p > n) begin
                return r;
            end
            m = n - p;
            g = '0;
            for (i = 0; i < p; i++) begin
                g[i] = groups[i];
            end
            for (i = 0; i < m; i++) begin
                g[8 - m + i] = groups[p + i];
            end
            groups   = g;
            n_groups = 8;
        end
        if (n_groups != 8) begin
            return r;
        end
        r.valid_res = 1'b1;
        r.upper     = {groups[0], groups[1], groups[2], groups[3]};
        r.lower     = {groups[4], groups[5], groups[6], groups[7]};
        return r;
    endfunction

    function automatic string octet_text();
        int v;
        case ($urandom_range(0, 39))
            0, 1, 2: v = 0;
            3, 4, 5: v = 255;
            6: v = $urandom_range(256, 999);
            default: v = $urandom_range(0, 255);
        endcase
        if ($urandom_range(0, 9) == 0) begin
            return $sformatf("0%0d", v);
        end
        return $sformatf("%0d", v);
    endfunction

    function automatic string quad_text(input int n);
        string s;
        int    i;
        s = octet_text();
        for (i = 1; i < n; i++) begin
            s = {s, ".", octet_text()};
        end
        return s;
    endfunction

    function automatic string group_text();
        string s;
        int    v;
        int    w;
        int    i;
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v = 16'hffff;
            default: v = $urandom_range(0, 16'hffff) >> ($urandom_range(0, 3) * 4);
        endcase
        s = $sformatf("%0h", v);
        w = $urandom_range(s.len(), 4);
        while (s.len() < w) begin
            s = {"0", s};
        end
        if (s.len() == 4 && $urandom_range(0, 49) == 0) begin
            s = {"1", s};
        end
        for (i = 0; i < s.len(); i++) begin
            if (s[i] >= "a" && s[i] <= "f" && $urandom_range(0, 1) == 1) begin
                s[i] = 8'(s[i] - 8'h20);
            end
        end
        return s;
    endfunction

    function automatic string v6_text();
        string parts [$];
        string s;
        logic  quad;
        logic  gap;
        int    total;
        int    n;
        int    cut;
        int    i;
        quad  = ($urandom_range(0, 3) == 0);
        gap   = ($urandom_range(0, 2) != 0);
        total = quad ? 6 : 8;
        if (gap) begin
            n = $urandom_range(0, total);
        end else if ($urandom_range(0, 19) == 0) begin
            n = $urandom_range(total - 1, total + 1);
        end else begin
            n = total;
        end
        for (i = 0; i < n; i++) begin
            parts.push_back(group_text());
        end
        if (quad) begin
            parts.push_back(quad_text(4));
        end
        cut = gap ? $urandom_range(0, n) : -1;
        s = "";
        for (i = 0; i < parts.size(); i++) begin
            if (i == cut) begin
                s = {s, "::"};
            end else if (i > 0) begin
                s = {s, ":"};
            end
            s = {s, parts[i]};
        end
        if (cut == parts.size()) begin
            s = {s, "::"};
        end
        return s;
    endfunction

    task automatic send_item(input logic [7:0] c, input logic eot);
        int idle_len;
        if (!calm && $urandom_range(0, 7) == 0) begin
            idle_len = $urandom_range(1, 15);
            repeat (idle_len) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_character   <= c;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_text(input logic [7:0] txt [$], input logic typed, input t_result want);
        t_result r;
        foreach (txt[i]) begin
            send_item(txt[i], 1'b0);
            scan_char(txt[i]);
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);
        r = address_of_text();
        clear_scan();
        pending_addrs.push_back(typed ? want : r);
    endtask

    task automatic set_family(input logic f);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_addrs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= FamilyAddr;
        i_pwdata  <= 32'(f);
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        @(negedge i_clk);
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        if (o_prdata !== 32'(f)) begin
            flag_error($sformatf("family readback: expected %h, got %h", 32'(f), o_prdata));
        end
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        fam_reg = f;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            n = $urandom_range(1, 20);
            repeat (n) begin
                @(negedge i_clk);
                i_stall <= 1'b0;
            end
            if (!calm) begin
                n = $urandom_range(1, 15);
                repeat (n) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("tb_ip_address_text_parser NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result due;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen = results_seen + 1;
            if (pending_addrs.size() == 0) begin
                flag_error($sformatf("transaction %0d arrived with nothing expected", results_seen));
            end else begin
                due = pending_addrs.pop_front();
                if (o_valid_res !== due.valid_res || o_address_upper !== due.upper
                        || o_address_lower !== due.lower) begin
                    flag_error($sformatf("transaction %0d: expected %b %h %h, got %b %h %h",
                        results_seen, due.valid_res, due.upper, due.lower,
                        o_valid_res, o_address_upper, o_address_lower));
                end
            end
        end
    end

    initial begin
        logic [7:0] txt [$];
        string      s;
        string      spice;
        int         k;
        int         p;
        int         i;
        int         n;
        int         sent;
        int         pick;
        logic       as_v6;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_character   = '0;
        i_end_of_text = 1'b0;
        i_psel        = 1'b0;
        i_penable     = 1'b0;
        i_pwrite      = 1'b0;
        i_paddr       = '0;
        i_pwdata      = '0;
        calm          = 1'b0;
        fam_reg       = 1'b0;
        spice         = ":.:0aF9.";
        clear_scan();

        vectors = '{
            '{1'b0, "",          1'b1, '{1'b0, 64'h0, 64'h0}},
            '{1'b0, "256",       1'b1, '{1'b0, 64'h0, 64'h0}},
            '{1'b0, "1.2.3.4",   1'b1, '{1'b1, 64'h0, 64'h0102_0304}},
            '{1'b1, "::",        1'b1, '{1'b1, 64'h0, 64'h0}},
            '{1'b1, "f:",        1'b1, '{1'b0, 64'h0, 64'h0}},
            '{1'b1, ":1",        1'b1, '{1'b0, 64'h0, 64'h0}},
            '{1'b1, "x::1",      1'b1, '{1'b0, 64'h0, 64'h0}},
            '{1'b1, "::1.2.3.4", 1'b0, '0},
            '{1'b1, "A::ffff",   1'b0, '0}
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < NumVectors; k++) begin
            if (vectors[k].fam != fam_reg) begin
                set_family(vectors[k].fam);
            end
            txt = {};
            for (i = 0; i < vectors[k].text.len(); i++) begin
                txt.push_back(vectors[k].text[i]);
            end
            send_text(txt, vectors[k].typed, vectors[k].want);
        end

        for (p = 0; p < NumPhases; p++) begin
            set_family(p[0]);
            calm = (p == NumPhases - 1);
            sent = 0;
            while (sent < ItemsPerPhase) begin
                txt  = {};
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    n = $urandom_range(0, 12);
                    repeat (n) txt.push_back(8'($urandom_range(0, 255)));
                end else begin
                    as_v6 = fam_reg ^ (pick == 1);
                    if (as_v6) begin
                        s = v6_text();
                    end else if ($urandom_range(0, 19) == 0) begin
                        s = quad_text($urandom_range(3, 5));
                    end else begin
                        s = quad_text(4);
                    end
                    for (i = 0; i < s.len(); i++) begin
                        txt.push_back(s[i]);
                    end
                    case ($urandom_range(0, 7))
                        0: begin
                            if (txt.size() > 0) begin
                                txt[$urandom_range(0, txt.size() - 1)] =
                                    8'($urandom_range(0, 255));
                            end
                        end
                        1: begin
                            txt.insert($urandom_range(0, txt.size()),
                                spice[$urandom_range(0, spice.len() - 1)]);
                        end
                        2: begin
                            if (txt.size() > 0) begin
                                txt.delete($urandom_range(0, txt.size() - 1));
                            end
                        end
                        3: begin
                            n = $urandom_range(0, txt.size());
                            while (txt.size() > n) void'(txt.pop_back());
                        end
                        default: begin
                        end
                    endcase
                end
                send_text(txt, 1'b0, '0);
                sent += txt.size() + 1;
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_addrs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_ip_address_text_parser OK");
        end else begin
            $display("tb_ip_address_text_parser NOT OK");
        end
        $finish;
    end

endmodule
